// ===== rtl/llm_pkg.sv =====
package llm_pkg;

    localparam int CIRCUITS  = 16;
    localparam int CIRC_W    = (CIRCUITS > 1) ? $clog2(CIRCUITS) : 1;

    localparam int CIRCUIT_W = 4;
    localparam int RTT_W     = 24;
    localparam int LOSS_W    = 20;
    localparam int MISS_W    = 8;
    localparam int CNT_W     = 32;
    localparam int CIN_W     = 5;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam int DIV_STEPS = LOSS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_DETECT_MULT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCUITS_IN_USE = 1'd1;

    localparam logic [MISS_W-1:0] DETECT_MULT_RESET = 8'd3;
    localparam logic [CIN_W-1:0]  CIN_RESET         = 5'd16;
    localparam logic [RTT_W-1:0]  RTT_RESET         = 24'd10000;
    localparam logic [LOSS_W-1:0] PPM_SCALE         = 20'd1000000;
    localparam logic [CNT_W-1:0]  CNT_MAX           = {CNT_W{1'b1}};
    localparam logic [MISS_W-1:0] MISS_MAX          = {MISS_W{1'b1}};

    typedef struct packed {
        logic [CIRCUIT_W-1:0] circuit;
        logic                 received;
        logic [RTT_W-1:0]     rtt_us;
    } probe_t;

    typedef struct packed {
        logic [CIRCUIT_W-1:0] circuit_out;
        logic                 is_up;
        logic [RTT_W-1:0]     avg_rtt_us;
        logic [LOSS_W-1:0]    loss_rate;
        logic                 went_up;
        logic                 went_down;
        logic [MISS_W-1:0]    misses;
        logic                 bad_circuit;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/llm_ifs.sv =====
interface llm_probe_if;
    import llm_pkg::*;

    logic   valid;
    logic   ready;
    probe_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface llm_result_if;
    import llm_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/link_liveness_monitor_unit.sv =====
// Link liveness monitor. Each transfer on the probe channel carries one probe
// outcome for a circuit: its index, whether it was answered, and the measured
// round-trip time. Each probe yields exactly one transfer on the result channel
// with the circuit's liveness, smoothed round-trip time, loss in parts per
// million, up and down events and the current miss run.
// A probe for a circuit not in use returns a result with bad_circuit set and
// changes nothing.
// A missed or rejected probe skips the multiplier and divider and goes from
// acceptance straight to the done state, which loads the output register.
// An answered probe first forms lost * 10^6 in a 32 by 20 bit multiplier, then
// runs 20 steps of a restoring divider, one quotient bit per cycle, then loads
// the output register. The block takes one probe at a time: a new probe is
// accepted only once the last result has been loaded into the output register.
// The result sits in an output register; a stalled receiver holds it, and the
// next probe is still accepted and processed up to the point of delivery.
// The configuration port takes writes at any cycle the write enable is high.
// Reset makes every circuit up with no samples, a smoothed round-trip time of
// 10000 us and zero counters, a detect multiplier of 3 and 16 circuits in use.
module link_liveness_monitor_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    llm_probe_if.sink                     probe,
    llm_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [llm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [llm_pkg::CFG_W-1:0]     cfg_data
);
    import llm_pkg::*;

    state_t state_reg, state_next;

    logic [MISS_W-1:0] detect_mult_reg;
    logic [CIN_W-1:0]  cin_reg;

    logic              up_reg     [CIRCUITS];
    logic [MISS_W-1:0] miss_reg   [CIRCUITS];
    logic [RTT_W-1:0]  rtt_reg    [CIRCUITS];
    logic              sample_reg [CIRCUITS];
    logic [CNT_W-1:0]  sent_reg   [CIRCUITS];
    logic [CNT_W-1:0]  recv_reg   [CIRCUITS];
    logic [LOSS_W-1:0] loss_reg   [CIRCUITS];

    logic [CIRC_W-1:0] idx_reg;
    logic              loss_wr_reg;
    result_t           work_reg;
    result_t           work_next;
    logic [CNT_W-1:0]  lost_reg;
    logic [CNT_W-1:0]  sor_reg;
    logic [CNT_W:0]    rem_reg;
    logic [LOSS_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;

    logic              accept;
    logic              load_out;
    logic [CIRC_W-1:0] idx;
    logic              bad;
    logic              rx;
    logic [CNT_W-1:0]  sent_new;
    logic [CNT_W-1:0]  recv_new;
    logic [MISS_W-1:0] miss_new;
    logic [RTT_W+1:0]  rtt_sum;
    logic [RTT_W-1:0]  rtt_new;
    logic              down_evt;
    logic              up_evt;
    logic [CNT_W+LOSS_W-1:0] prod;
    logic [CNT_W:0]    trial;
    logic              ge;

    assign probe.ready  = (state_reg == ST_IDLE);
    assign accept       = probe.valid && probe.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    assign idx = CIRC_W'(probe.data.circuit);
    assign bad = ({1'b0, probe.data.circuit} >= cin_reg)
              || (32'(probe.data.circuit) >= CIRCUITS);
    assign rx  = probe.data.received;

    assign sent_new = (sent_reg[idx] == CNT_MAX) ? CNT_MAX : sent_reg[idx] + 1'b1;
    assign recv_new = (recv_reg[idx] == CNT_MAX) ? CNT_MAX : recv_reg[idx] + 1'b1;
    assign miss_new = (miss_reg[idx] == MISS_MAX) ? MISS_MAX : miss_reg[idx] + 1'b1;
    assign rtt_sum  = {1'b0, rtt_reg[idx], 1'b0} + {2'b00, rtt_reg[idx]}
                    + {2'b00, probe.data.rtt_us};
    assign rtt_new  = sample_reg[idx] ? rtt_sum[RTT_W+1:2] : probe.data.rtt_us;
    assign down_evt = !rx && up_reg[idx] && (miss_new >= detect_mult_reg);
    assign up_evt   = rx && !up_reg[idx];

    assign prod  = (CNT_W+LOSS_W)'(lost_reg) * (CNT_W+LOSS_W)'(PPM_SCALE);
    assign trial = {rem_reg[CNT_W-1:0], quo_reg[LOSS_W-1]};
    assign ge    = (trial >= {1'b0, sor_reg});

    always_comb
    begin
        work_next             = '0;
        work_next.circuit_out = probe.data.circuit;
        if (bad)
        begin
            work_next.bad_circuit = 1'b1;
        end
        else
        begin
            work_next.is_up      = rx || (up_reg[idx] && !down_evt);
            work_next.avg_rtt_us = rx ? rtt_new : rtt_reg[idx];
            work_next.went_up    = up_evt;
            work_next.went_down  = down_evt;
            work_next.misses     = rx ? '0 : miss_new;
        end
    end

    always_comb
    begin
        res_next           = work_reg;
        res_next.loss_rate = work_reg.bad_circuit ? '0 : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (rx && !bad) ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_mult_reg <= DETECT_MULT_RESET;
            cin_reg         <= CIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DETECT_MULT:     detect_mult_reg <= cfg_data[MISS_W-1:0];
                REG_CIRCUITS_IN_USE: cin_reg         <= cfg_data[CIN_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CIRCUITS; i++)
            begin
                up_reg[i]     <= 1'b1;
                miss_reg[i]   <= '0;
                rtt_reg[i]    <= RTT_RESET;
                sample_reg[i] <= 1'b0;
                sent_reg[i]   <= '0;
                recv_reg[i]   <= '0;
                loss_reg[i]   <= '0;
            end
        end
        else
        begin
            if (accept && !bad)
            begin
                sent_reg[idx] <= sent_new;
                if (rx)
                begin
                    miss_reg[idx]   <= '0;
                    recv_reg[idx]   <= recv_new;
                    rtt_reg[idx]    <= rtt_new;
                    sample_reg[idx] <= 1'b1;
                    up_reg[idx]     <= 1'b1;
                end
                else
                begin
                    miss_reg[idx] <= miss_new;
                    if (down_evt)
                    begin
                        up_reg[idx] <= 1'b0;
                    end
                end
            end
            if (load_out && loss_wr_reg)
            begin
                loss_reg[idx_reg] <= quo_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg     <= idx;
            loss_wr_reg <= rx && !bad;
            work_reg    <= work_next;
            quo_reg     <= bad ? '0 : loss_reg[idx];
            lost_reg    <= (sent_new >= recv_new) ? sent_new - recv_new : '0;
            sor_reg     <= sent_new;
        end
        if (state_reg == ST_MUL)
        begin
            rem_reg     <= {1'b0, prod[CNT_W+LOSS_W-1:LOSS_W]};
            quo_reg     <= prod[LOSS_W-1:0];
            div_cnt_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg     <= ge ? trial - {1'b0, sor_reg} : trial;
            quo_reg     <= {quo_reg[LOSS_W-2:0], ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/llm_checker.sv =====
module llm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input llm_pkg::result_t res
);
    import llm_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res))
        else $error("result changed or dropped while stalled");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res.bad_circuit |-> !res.is_up && res.avg_rtt_us == '0
            && res.loss_rate == '0 && !res.went_up && !res.went_down
            && res.misses == '0)
        else $error("rejected probe result carries state");

    a_up_evt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res.went_up |-> res.is_up && res.misses == '0 && !res.went_down)
        else $error("inconsistent up event");

    a_down_evt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res.went_down |-> !res.is_up && res.misses != '0)
        else $error("inconsistent down event");

endmodule

bind link_liveness_monitor_unit llm_checker u_llm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (result.data)
);

// ===== dv/tb_link_liveness_monitor_unit.sv =====
module tb_link_liveness_monitor_unit;
    import llm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    llm_probe_if  probe_ch ();
    llm_result_if result_ch ();

    link_liveness_monitor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe     (probe_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Expected behavior of every circuit, kept alongside the block.
    logic [CIRCUITS-1:0] circ_up;
    logic [CIRCUITS-1:0] circ_sampled;
    logic [MISS_W-1:0]   circ_misses [CIRCUITS];
    logic [RTT_W-1:0]    circ_rtt    [CIRCUITS];
    logic [CNT_W-1:0]    circ_sent   [CIRCUITS];
    logic [CNT_W-1:0]    circ_recv   [CIRCUITS];
    logic [LOSS_W-1:0]   circ_loss   [CIRCUITS];
    logic [MISS_W-1:0]   model_mult;
    logic [CIN_W-1:0]    model_in_use;

    result_t expected_outcomes [$];
    int      errors      = 0;
    int      cycle_count = 0;
    bit      steady      = 1'b0;
    bit      hold_request = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 90);
    endfunction

    function automatic logic [RTT_W-1:0] pick_rtt();
        case ($urandom_range(0, 3))
            0: return RTT_W'($urandom);
            1: return RTT_W'($urandom_range(0, 2000));
            2: return RTT_W'($urandom_range(9000, 11000));
            default: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        endcase
    endfunction

    function automatic result_t predict_outcome(probe_t p);
        result_t          r;
        int unsigned      c;
        logic [CNT_W-1:0] lost;
        logic [63:0]      wide;
        r = '0;
        r.circuit_out = p.circuit;
        c = 32'(p.circuit);
        if (c >= model_in_use || c >= CIRCUITS)
        begin
            r.bad_circuit = 1'b1;
            return r;
        end
        if (circ_sent[c] != CNT_MAX)
            circ_sent[c] = circ_sent[c] + 1;
        if (p.received)
        begin
            circ_misses[c] = '0;
            if (circ_recv[c] != CNT_MAX)
                circ_recv[c] = circ_recv[c] + 1;
            if (!circ_sampled[c])
                circ_rtt[c] = p.rtt_us;
            else
            begin
                wide = {40'd0, circ_rtt[c]} * 64'd3 + {40'd0, p.rtt_us};
                circ_rtt[c] = wide[RTT_W+1:2];
            end
            circ_sampled[c] = 1'b1;
            lost = (circ_sent[c] >= circ_recv[c]) ? circ_sent[c] - circ_recv[c] : '0;
            if (circ_sent[c] != 0)
            begin
                wide = ({32'd0, lost} * 64'd1000000) / {32'd0, circ_sent[c]};
                circ_loss[c] = wide[LOSS_W-1:0];
            end
            if (!circ_up[c])
            begin
                circ_up[c] = 1'b1;
                r.went_up = 1'b1;
            end
        end
        else
        begin
            if (circ_misses[c] != MISS_MAX)
                circ_misses[c] = circ_misses[c] + 1'b1;
            if (circ_misses[c] >= model_mult && circ_up[c])
            begin
                circ_up[c] = 1'b0;
                r.went_down = 1'b1;
            end
        end
        r.is_up      = circ_up[c];
        r.avg_rtt_us = circ_rtt[c];
        r.loss_rate  = circ_loss[c];
        r.misses     = circ_misses[c];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic compare_outcome(input result_t got);
        result_t want;
        if (expected_outcomes.size() == 0)
        begin
            $display("%0t: circuit_out expected none actual %0h", $time, got.circuit_out);
            errors++;
            return;
        end
        want = expected_outcomes.pop_front();
        check_field("circuit_out", 32'(want.circuit_out), 32'(got.circuit_out));
        check_field("is_up", 32'(want.is_up), 32'(got.is_up));
        check_field("avg_rtt_us", 32'(want.avg_rtt_us), 32'(got.avg_rtt_us));
        check_field("loss_rate", 32'(want.loss_rate), 32'(got.loss_rate));
        check_field("went_up", 32'(want.went_up), 32'(got.went_up));
        check_field("went_down", 32'(want.went_down), 32'(got.went_down));
        check_field("misses", 32'(want.misses), 32'(got.misses));
        check_field("bad_circuit", 32'(want.bad_circuit), 32'(got.bad_circuit));
    endtask

    initial
    begin
        int n;
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                compare_outcome(result_ch.data);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    stall_left = n - 1;
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic send_probe(input logic [CIRCUIT_W-1:0] circuit, input logic received,
                              input logic [RTT_W-1:0] rtt);
        int     gap;
        probe_t p;
        p.circuit  = circuit;
        p.received = received;
        p.rtt_us   = rtt;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            probe_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        probe_ch.valid <= 1'b1;
        probe_ch.data  <= p;
        do
            @(posedge clk);
        while (!probe_ch.ready);
        expected_outcomes.push_back(predict_outcome(p));
    endtask

    task automatic drain_results();
        probe_ch.valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        if (idx == REG_DETECT_MULT)
            model_mult = value;
        else
            model_in_use = value[CIN_W-1:0];
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_probe(4'd0, 1'b1, 24'h000000);
        send_probe(4'd15, 1'b1, 24'hFFFFFF);
        send_probe(4'd15, 1'b1, 24'h000000);
        repeat (4) send_probe(4'd1, 1'b0, 24'hFFFFFF);
        send_probe(4'd1, 1'b1, 24'd123);
    endtask

    task automatic test_register_writes();
        drain_results();
        // Only the low bits of a register write are kept.
        write_reg(REG_CIRCUITS_IN_USE, 8'hE4);
        send_probe(4'd4, 1'b0, 24'd5);
        send_probe(4'd3, 1'b1, 24'd77);
        send_probe(4'd15, 1'b1, 24'd99);
        drain_results();
        write_reg(REG_CIRCUITS_IN_USE, 8'h20);
        send_probe(4'd0, 1'b1, 24'd1);
        drain_results();
        write_reg(REG_CIRCUITS_IN_USE, 8'h1F);
        write_reg(REG_DETECT_MULT, 8'd0);
        send_probe(4'd7, 1'b0, 24'd0);
        send_probe(4'd7, 1'b1, 24'd40);
        drain_results();
        write_reg(REG_DETECT_MULT, 8'd1);
        send_probe(4'd8, 1'b0, 24'd0);
        drain_results();
        write_reg(REG_DETECT_MULT, 8'd3);
        write_reg(REG_CIRCUITS_IN_USE, 8'h10);
    endtask

    task automatic test_miss_saturation();
        drain_results();
        write_reg(REG_DETECT_MULT, 8'hFF);
        repeat (260) send_probe(4'd5, 1'b0, pick_rtt());
        send_probe(4'd5, 1'b1, pick_rtt());
        drain_results();
    endtask

    task automatic test_result_backpressure();
        drain_results();
        steady = 1'b1;
        hold_request = 1'b1;
        repeat (24) send_probe(CIRCUIT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                               pick_rtt());
        drain_results();
        steady = 1'b0;
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] mult,
                                    input logic [CFG_W-1:0] in_use, input int count);
        int                   served;
        int                   len;
        int                   span;
        int                   r;
        logic [CIRCUIT_W-1:0] c;
        drain_results();
        write_reg(REG_DETECT_MULT, mult);
        write_reg(REG_CIRCUITS_IN_USE, in_use);
        served = 0;
        span = (model_in_use > CIRCUITS) ? CIRCUITS : int'(model_in_use);
        while (served < count)
        begin
            if ($urandom_range(0, 9) == 0)
                steady = !steady;
            r = $urandom_range(0, 99);
            c = CIRCUIT_W'($urandom_range(0, span - 1));
            if (r < 40)
            begin
                // A run of misses near the detect threshold (a short run for a high threshold), then mostly a recovery.
                if (model_mult <= 20)
                    len = $urandom_range((model_mult > 1) ? model_mult - 1 : 0, model_mult + 2);
                else
                    len = $urandom_range(1, 6);
                repeat (len) send_probe(c, 1'b0, pick_rtt());
                served += len;
                if ($urandom_range(0, 9) < 7)
                begin
                    send_probe(c, 1'b1, pick_rtt());
                    served++;
                end
            end
            else if (r < 48)
            begin
                c = CIRCUIT_W'($urandom_range(0, 15));
                send_probe(c, 1'($urandom_range(0, 1)), pick_rtt());
                if (c < model_in_use)
                    served++;
            end
            else
            begin
                send_probe(c, 1'($urandom_range(0, 1)), pick_rtt());
                served++;
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(8'd1, 8'h01, 64);
        run_random_phase(8'd2, 8'h05, 64);
        run_random_phase(8'hFF, 8'h10, 64);
        run_random_phase(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 16)), 64);
        run_random_phase(8'd0, 8'hFF, 64);
        drain_results();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_DETECT_MULT;
        cfg_data       <= '0;
        probe_ch.valid <= 1'b0;
        probe_ch.data  <= '0;
        model_mult   = DETECT_MULT_RESET;
        model_in_use = CIN_RESET;
        circ_up      = '1;
        circ_sampled = '0;
        for (int i = 0; i < CIRCUITS; i++)
        begin
            circ_misses[i] = '0;
            circ_rtt[i]    = RTT_RESET;
            circ_sent[i]   = '0;
            circ_recv[i]   = '0;
            circ_loss[i]   = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_writes();
        test_miss_saturation();
        test_result_backpressure();
        test_random_traffic();

        drain_results();
        repeat (30) @(posedge clk);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/llm_pkg.sv
rtl/llm_ifs.sv
rtl/link_liveness_monitor_unit.sv
rtl/llm_checker.sv
dv/tb_link_liveness_monitor_unit.sv
